// ----- hw/rtl/yuyv565_pkg.sv -----
// ----------------------------------------------------------------------------
// yuyv565_pkg
// Shared types and constants of the YUYV pair to RGB565 converter: BT.601
// coefficients, register indexes, reset sizes and the coordinate record.
// ----------------------------------------------------------------------------
package yuyv565_pkg;

    // Frame geometry
    localparam int COORD_LIMIT_DEFAULT = 1024;
    localparam int CFG_WIDTH           = 11;
    localparam int COORD_OUT_WIDTH     = 10;

    localparam logic [CFG_WIDTH-1:0] FRAME_WIDTH_RESET  = 11'd240;
    localparam logic [CFG_WIDTH-1:0] FRAME_HEIGHT_RESET = 11'd240;

    // Configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // BT.601 limited range, coefficients scaled by 256
    localparam int LUMA_OFFSET   = 16;
    localparam int CHROMA_OFFSET = 128;
    localparam int K_Y           = 298;
    localparam int K_RV          = 409;
    localparam int K_GU          = 100;
    localparam int K_GV          = 208;
    localparam int K_BU          = 516;
    localparam int K_ROUND       = 128;

    // Position of one pixel pair in the frame
    typedef struct packed {
        logic [COORD_OUT_WIDTH-1:0] column;
        logic [COORD_OUT_WIDTH-1:0] row;
        logic                       end_of_frame;
    } pos_t;

endpackage

// ----- hw/rtl/yuyv565_coord.sv -----
// ----------------------------------------------------------------------------
// yuyv565_coord
// Column and row counters over a frame of programmable size. Reports the
// position of the pair being accepted and advances on each accepted word.
// ----------------------------------------------------------------------------
module yuyv565_coord
    import yuyv565_pkg::*;
#(
    parameter int COORD_LIMIT = COORD_LIMIT_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [CFG_WIDTH-1:0] frame_width,
    input  logic [CFG_WIDTH-1:0] frame_height,
    output pos_t                 pos
);

    localparam int CW = $clog2(COORD_LIMIT);
    // compare width: holds the limit, the raw register and counter + 2
    localparam int SW = (CW + 1 > CFG_WIDTH) ? CW + 1 : CFG_WIDTH;
    localparam int XW = (CW > COORD_OUT_WIDTH) ? CW : COORD_OUT_WIDTH;

    logic [CW-1:0] column_reg, column_next;
    logic [CW-1:0] row_reg, row_next;
    logic [SW-1:0] width_even;
    logic [SW-1:0] width_eff;
    logic [SW-1:0] height_eff;
    logic [XW-1:0] column_ext;
    logic [XW-1:0] row_ext;
    logic          row_end;
    logic          last_row;

    // effective size: drop the odd width bit, floor at one pair / one row,
    // saturate at the limit
    always_comb begin
        width_even = SW'(frame_width) & ~SW'(1);
        if (width_even < SW'(2)) begin
            width_eff = SW'(2);
        end else if (width_even > SW'(COORD_LIMIT)) begin
            width_eff = SW'(COORD_LIMIT);
        end else begin
            width_eff = width_even;
        end
        if (frame_height == '0) begin
            height_eff = SW'(1);
        end else if (SW'(frame_height) > SW'(COORD_LIMIT)) begin
            height_eff = SW'(COORD_LIMIT);
        end else begin
            height_eff = SW'(frame_height);
        end
    end

    // "at or beyond" so a counter left past a shrunk size wraps at once
    assign row_end  = (SW'(column_reg) + SW'(2)) >= width_eff;
    assign last_row = (SW'(row_reg) + SW'(1)) >= height_eff;

    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        if (advance) begin
            if (row_end) begin
                column_next = '0;
                row_next    = last_row ? '0 : row_reg + CW'(1);
            end else begin
                column_next = column_reg + CW'(2);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    assign column_ext       = XW'(column_reg);
    assign row_ext          = XW'(row_reg);
    assign pos.column       = column_ext[COORD_OUT_WIDTH-1:0];
    assign pos.row          = row_ext[COORD_OUT_WIDTH-1:0];
    assign pos.end_of_frame = row_end && last_row;

endmodule

// ----- hw/rtl/yuyv565_convert.sv -----
// ----------------------------------------------------------------------------
// yuyv565_convert
// One pixel of BT.601 limited-range YCbCr to RGB565: constant multiplies,
// rounding, floor shift, clamp to 0..255 and 5-6-5 packing.
// ----------------------------------------------------------------------------
module yuyv565_convert
    import yuyv565_pkg::*;
(
    input  logic [7:0]  luma,
    input  logic [7:0]  chroma_u,
    input  logic [7:0]  chroma_v,
    output logic [15:0] pixel
);

    localparam int AW = 19;

    logic signed [AW-1:0] c, d, e;
    logic signed [AW-1:0] y_term;
    logic signed [AW-1:0] red_acc, green_acc, blue_acc;
    logic [7:0]           red, green, blue;

    function automatic logic [7:0] clamp_channel(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] shifted;
        logic signed [AW-9:0] q;
        shifted = acc >>> 8;
        q       = shifted[AW-9:0];
        if (q < 0) begin
            return 8'd0;
        end else if (q > 255) begin
            return 8'd255;
        end else begin
            return q[7:0];
        end
    endfunction

    always_comb begin
        c = $signed(AW'(luma))     - AW'(LUMA_OFFSET);
        d = $signed(AW'(chroma_u)) - AW'(CHROMA_OFFSET);
        e = $signed(AW'(chroma_v)) - AW'(CHROMA_OFFSET);

        y_term    = c * AW'(K_Y) + AW'(K_ROUND);
        red_acc   = y_term + e * AW'(K_RV);
        green_acc = y_term - d * AW'(K_GU) - e * AW'(K_GV);
        blue_acc  = y_term + d * AW'(K_BU);

        red   = clamp_channel(red_acc);
        green = clamp_channel(green_acc);
        blue  = clamp_channel(blue_acc);

        pixel = {red[7:3], green[7:2], blue[7:3]};
    end

endmodule

// ----- hw/rtl/yuyv_pair_to_rgb565.sv -----
// ----------------------------------------------------------------------------
// yuyv_pair_to_rgb565
// Streaming YUYV macropixel to RGB565 pixel pair converter with frame
// column / row tracking and an end-of-frame marker.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake             Word contents
//  -------  ---  --------------------  ------------------------------------
//  s_       in   s_tvalid / s_tready   one YUYV macropixel (Y0 U Y1 V)
//  m_       out  m_tvalid / m_tready   two RGB565 pixels, column, row; tlast
//                                      flags the last pair of the frame
//  cfg_     in   cfg_wr_en             frame_width (0), frame_height (1)
//
//  Throughput is one word per cycle while m_ does not stall; a word accepted
//  on s_ passes the input register, then the result register, before
//  m_tvalid shows it.
//  The conversion is a single combinational pass between those registers.
//  Reset (aresetn low at a clock edge) empties both registers, clears the
//  counters and loads 240 x 240. A stall on m_ holds the result register;
//  the input register still takes one more word, so s_tready drops only
//  when both are full.
//
// ----------------------------------------------------------------------------
module yuyv_pair_to_rgb565
    import yuyv565_pkg::*;
#(
    parameter int COORD_LIMIT = COORD_LIMIT_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // config write port
    input  logic                 cfg_wr_en,
    input  logic                 cfg_addr,
    input  logic [CFG_WIDTH-1:0] cfg_wr_data,

    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] luma_first, [15:8] chroma_u, [23:16] luma_second, [31:24] chroma_v
    input  logic [31:0]          s_tdata,

    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] pixel_even, [31:16] pixel_odd, [41:32] column, [51:42] row,
    // [55:52] zero
    output logic [55:0]          m_tdata,
    output logic                 m_tlast
);

    logic [CFG_WIDTH-1:0] frame_width_reg;
    logic [CFG_WIDTH-1:0] frame_height_reg;

    logic        s_accept;
    pos_t        pos_in;

    // input register
    logic        s1_valid_reg;
    logic        s1_ready;
    logic [31:0] s1_data_reg;
    pos_t        s1_pos_reg;

    // conversion outputs
    logic [15:0] pix_even;
    logic [15:0] pix_odd;

    // result register
    logic        m_valid_reg;
    logic [15:0] m_pix_even_reg;
    logic [15:0] m_pix_odd_reg;
    pos_t        m_pos_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // -------------------------------------------------------------- handshake
    // Advance the input register whenever the result register frees up.
    assign s1_ready = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_ready;
    assign s_accept = s_tvalid && s_tready;

    // -------------------------------------------------------- frame position
    yuyv565_coord #(
        .COORD_LIMIT (COORD_LIMIT)
    ) u_coord (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (s_accept),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pos          (pos_in)
    );

    // --------------------------------------------------------- input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // capture payload together with the position it was accepted at
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_data_reg <= s_tdata;
            s1_pos_reg  <= pos_in;
        end
    end

    // ------------------------------------------------------------- conversion
    yuyv565_convert u_convert_even (
        .luma     (s1_data_reg[7:0]),
        .chroma_u (s1_data_reg[15:8]),
        .chroma_v (s1_data_reg[31:24]),
        .pixel    (pix_even)
    );

    yuyv565_convert u_convert_odd (
        .luma     (s1_data_reg[23:16]),
        .chroma_u (s1_data_reg[15:8]),
        .chroma_v (s1_data_reg[31:24]),
        .pixel    (pix_odd)
    );

    // -------------------------------------------------------- result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    // load on a move out of the input register, hold while stalled
    always_ff @(posedge aclk) begin
        if (s1_ready && s1_valid_reg) begin
            m_pix_even_reg <= pix_even;
            m_pix_odd_reg  <= pix_odd;
            m_pos_reg      <= s1_pos_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_pos_reg.row, m_pos_reg.column,
                       m_pix_odd_reg, m_pix_even_reg};
    assign m_tlast  = m_pos_reg.end_of_frame;

endmodule

// ----- hw/rtl/yuyv565_checker.sv -----
// ----------------------------------------------------------------------------
// yuyv565_checker
// Port-level checks of the YUYV to RGB565 converter, bound to the top level.
// ----------------------------------------------------------------------------
module yuyv565_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds its word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    // column steps by two from zero, so it is always even
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[32])
        else $error("odd column reported");

    // with space in the result register the input side never stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind yuyv_pair_to_rgb565 yuyv565_checker u_yuyv565_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_tready    (s_tready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb - yuyv_pair_to_rgb565 testbench
// Streams YUYV macropixels through the converter under several frame sizes
// and idling patterns, predicts each RGB565 pair with its frame position
// and end-of-frame flag, and compares every result word field by field.
// ----------------------------------------------------------------------------
module tb
    import yuyv565_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 950;

    // ------------------------------------------------------------------
    // Pair predictor: tracks frame size and position, holds the pairs
    // still owed by the block and checks each result word against them.
    // ------------------------------------------------------------------
    class rgb_pair_predictor;
        typedef struct {
            logic [15:0] pixel_even;
            logic [15:0] pixel_odd;
            logic [9:0]  column;
            logic [9:0]  row;
            logic        end_of_frame;
        } pair_t;

        pair_t       expected_pairs[$];
        logic [10:0] width_reg;
        logic [10:0] height_reg;
        int unsigned col_count;
        int unsigned row_count;
        int          mismatches;

        function new();
            width_reg  = 11'd240;
            height_reg = 11'd240;
            col_count  = 0;
            row_count  = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic addr, logic [10:0] value);
            if (addr == REG_FRAME_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
        endfunction

        // acc is already divided by 256 (floor); clamp to one byte
        function logic [7:0] saturate(int acc);
            if (acc < 0) return 8'd0;
            if (acc > 255) return 8'd255;
            return acc[7:0];
        endfunction

        function logic [15:0] to_rgb565(logic [7:0] y, logic [7:0] u, logic [7:0] v);
            int          c;
            int          d;
            int          e;
            logic [7:0]  r;
            logic [7:0]  g;
            logic [7:0]  b;
            c = int'(y) - 16;
            d = int'(u) - 128;
            e = int'(v) - 128;
            // arithmetic shift of a signed int floors toward minus infinity
            r = saturate((298 * c + 409 * e + 128) >>> 8);
            g = saturate((298 * c - 100 * d - 208 * e + 128) >>> 8);
            b = saturate((298 * c + 516 * d + 128) >>> 8);
            return {r[7:3], g[7:2], b[7:3]};
        endfunction

        function int unsigned span_width();
            int unsigned w;
            w = int'(width_reg & 11'h7FE);
            if (w < 2) w = 2;
            if (w > COORD_LIMIT_DEFAULT) w = COORD_LIMIT_DEFAULT;
            return w;
        endfunction

        function int unsigned span_height();
            int unsigned h;
            h = int'(height_reg);
            if (h < 1) h = 1;
            if (h > COORD_LIMIT_DEFAULT) h = COORD_LIMIT_DEFAULT;
            return h;
        endfunction

        function void note_macropixel(logic [31:0] word);
            pair_t       p;
            bit          row_end;
            bit          last_row;
            row_end  = (col_count + 2 >= span_width());
            last_row = (row_count + 1 >= span_height());
            p.pixel_even   = to_rgb565(word[7:0], word[15:8], word[31:24]);
            p.pixel_odd    = to_rgb565(word[23:16], word[15:8], word[31:24]);
            p.column       = col_count[9:0];
            p.row          = row_count[9:0];
            p.end_of_frame = row_end && last_row;
            expected_pairs.push_back(p);
            // counters wrap on "at or beyond", so a shrunken frame wraps at once
            if (row_end) begin
                col_count = 0;
                row_count = last_row ? 0 : row_count + 1;
            end else begin
                col_count = col_count + 2;
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %h, got %h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_pair(logic [55:0] data, logic last);
            pair_t p;
            if (expected_pairs.size() == 0) begin
                $error("result word with nothing pending: %h", data);
                mismatches++;
                return;
            end
            p = expected_pairs.pop_front();
            compare_field("pixel_even", p.pixel_even, data[15:0]);
            compare_field("pixel_odd", p.pixel_odd, data[31:16]);
            compare_field("column", 16'(p.column), 16'(data[41:32]));
            compare_field("row", 16'(p.row), 16'(data[51:42]));
            compare_field("pad", 16'd0, 16'(data[55:52]));
            compare_field("end_of_frame", 16'(p.end_of_frame), 16'(last));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, DUT and its inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_addr    = 1'b0;
    logic [10:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;  // [7:0] Y0, [15:8] U, [23:16] Y1, [31:24] V
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [55:0] m_tdata;           // [15:0] even, [31:16] odd, [41:32] column, [51:42] row
    logic        m_tlast;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          words_sent     = 0;
    int          cycle_count    = 0;

    rgb_pair_predictor predictor = new();

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    yuyv_pair_to_rgb565 DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // Receiver: drop ready at random on the falling edge, check every
    // accepted word on the rising edge.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            predictor.check_pair(m_tdata, m_tlast);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[yuyv_pair_to_rgb565] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Every task is entered and left on a falling edge.
    // ------------------------------------------------------------------

    // Offer one macropixel; valid stays high after the handshake so
    // back-to-back words need no gap.
    task automatic send_macropixel(input logic [31:0] word);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = word;
        do @(posedge aclk); while (!s_tready);
        predictor.note_macropixel(word);
        words_sent++;
        @(negedge aclk);
    endtask

    // Stop offering words, wait for all pending pairs, then let the two
    // pipeline registers settle.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (predictor.expected_pairs.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_size(input logic addr, input logic [10:0] value);
        cfg_wr_en   = 1'b1;
        cfg_addr    = addr;
        cfg_wr_data = value;
        @(negedge aclk);
        predictor.write_reg(addr, value);
        cfg_wr_en   = 1'b0;
    endtask

    // Resize only while the block is idle; counters keep their position.
    task automatic set_frame(input logic [10:0] w, input logic [10:0] h);
        drain_results();
        write_size(REG_FRAME_WIDTH, w);
        write_size(REG_FRAME_HEIGHT, h);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 62;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 62;
            end
            default: begin
                send_idle_pct  = 19;
                recv_stall_pct = 19;
            end
        endcase
    endtask

    // Sample byte biased toward the clamp and offset corners.
    function automatic logic [7:0] pick_sample();
        if ($urandom_range(3, 0) != 0) return 8'($urandom);
        case ($urandom_range(6, 0))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd16;
            3: return 8'd235;
            4: return 8'd128;
            5: return 8'd1;
            default: return 8'd254;
        endcase
    endfunction

    task automatic send_samples(input logic [7:0] y0, input logic [7:0] u,
                                input logic [7:0] y1, input logic [7:0] v);
        send_macropixel({v, y1, u, y0});
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int          phase;
        int          count;
        logic [10:0] w;
        logic [10:0] h;

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Conversion corners at the reset frame size: all-zero and all-one
        // bytes, black and white levels, neutral chroma, clamp both ways.
        set_idling(0);
        send_samples(8'd0, 8'd0, 8'd255, 8'd0);
        send_samples(8'd255, 8'd255, 8'd0, 8'd255);
        send_samples(8'd16, 8'd128, 8'd235, 8'd128);
        send_samples(8'd0, 8'd128, 8'd255, 8'd128);
        send_samples(8'd255, 8'd0, 8'd0, 8'd255);
        send_samples(8'd0, 8'd255, 8'd255, 8'd0);
        send_samples(8'hAA, 8'h55, 8'h55, 8'hAA);
        send_samples(8'h55, 8'hAA, 8'hAA, 8'h55);

        // Smallest frame: every pair ends a frame.
        set_frame(11'd2, 11'd1);
        repeat (2) send_macropixel($urandom);

        // Width below two and height zero fall back to 2 x 1.
        set_frame(11'd0, 11'd0);
        repeat (2) send_macropixel($urandom);

        // Odd width bit is ignored.
        set_frame(11'd3, 11'd2);
        repeat (3) send_macropixel($urandom);

        // Sizes above the coordinate limit saturate.
        set_frame(11'h7FF, 11'h7FF);
        repeat (2) send_macropixel($urandom);

        // Shrink mid-frame: the column already lies beyond the new width,
        // so the next pair reports it and wraps on the same step.
        set_frame(11'd64, 11'd3);
        repeat (4) send_macropixel($urandom);
        set_frame(11'd4, 11'd3);
        repeat (2) send_macropixel($urandom);

        // Random phases: mostly small frames so rows and frames wrap often,
        // now and then a wild register value.
        phase = 0;
        while (words_sent < RANDOM_WORDS) begin
            case ($urandom_range(7, 0))
                0: begin
                    w = 11'($urandom_range(2047, 0));
                    h = 11'($urandom_range(3, 0));
                end
                1: begin
                    w = 11'($urandom_range(3, 0));
                    h = 11'($urandom_range(2047, 0));
                end
                default: begin
                    w = 11'($urandom_range(40, 2));
                    h = 11'($urandom_range(6, 1));
                end
            endcase
            set_frame(w, h);
            set_idling(phase % 4);
            count = $urandom_range(60, 8);
            repeat (count) send_samples(pick_sample(), pick_sample(),
                                        pick_sample(), pick_sample());
            phase++;
        end

        set_idling(0);
        drain_results();
        if (predictor.mismatches == 0 && predictor.expected_pairs.size() == 0) begin
            $display("[yuyv_pair_to_rgb565] OK");
        end else begin
            $display("[yuyv_pair_to_rgb565] ERROR");
        end
        $finish;
    end

endmodule
